[rtl/core/tkr_pkg.sv]
// ----------------------------------------------------------------------------
// tkr_pkg - shared types and constants of the ranking table
// entry layout, queue command, rank order compare and table sizing
// ----------------------------------------------------------------------------
package tkr_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int RANK_W     = 6;
    localparam int YEAR_W     = 14;
    localparam int DATE_W     = 27;
    localparam logic [YEAR_W-1:0] YEAR_DIVISOR = YEAR_W'(10000);

    typedef struct packed {
        logic        [15:0]       group;
        logic signed [15:0]       days;
        logic        [DATE_W-1:0] date;
        logic signed [31:0]       score;
        logic        [31:0]       id;
    } entry_t;

    typedef enum logic {
        CMD_OFFER = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        entry_t    entry;
    } cmd_t;

    // true when a ranks strictly before b
    function automatic logic ranks_before(input entry_t a, input entry_t b);
        logic res;
        if (a.score != b.score) begin
            res = (a.score > b.score);
        end else if (a.date != b.date) begin
            res = (a.date < b.date);
        end else begin
            res = (a.id < b.id);
        end
        return res;
    endfunction

endpackage

[rtl/core/tkr_front.sv]
// ----------------------------------------------------------------------------
// tkr_front - input word classification
// holds the year register, drops unusable offers, forwards the rest
// ----------------------------------------------------------------------------
module tkr_front import tkr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [YEAR_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_op,
    input  entry_t            in_entry,
    output logic              push,
    output cmd_t              push_cmd,
    input  logic              q_full
);

    logic [YEAR_W-1:0] year_reg;
    logic [DATE_W:0]   year_lo;
    logic [DATE_W:0]   year_hi;
    logic              keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg <= '0;
        end else if (cfg_we) begin
            year_reg <= cfg_wdata;
        end
    end

    // year window: lo <= date < lo + 10000
    assign year_lo = (DATE_W+1)'(year_reg * YEAR_DIVISOR);
    assign year_hi = year_lo + (DATE_W+1)'(YEAR_DIVISOR);

    always_comb begin
        keep = (in_entry.id != '0) && (in_entry.days > 16'sd0)
            && (in_entry.date != '0) && (year_reg != '0)
            && ({1'b0, in_entry.date} >= year_lo)
            && ({1'b0, in_entry.date} < year_hi);
    end

    assign in_ready       = !q_full;
    assign push           = in_valid && !q_full && (in_op || keep);
    assign push_cmd.kind  = in_op ? CMD_DRAIN : CMD_OFFER;
    assign push_cmd.entry = in_entry;

endmodule

[rtl/core/tkr_queue.sv]
// ----------------------------------------------------------------------------
// tkr_queue - two-entry command queue
// decouples classification from table work
// ----------------------------------------------------------------------------
module tkr_queue import tkr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = mem_reg[rd_ptr_reg];

endmodule

[rtl/core/tkr_back.sv]
// ----------------------------------------------------------------------------
// tkr_back - table store and command sequencer
// scans slots one per cycle for offers and selection-sorted drains
// ----------------------------------------------------------------------------
module tkr_back import tkr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_res,
    output logic [RANK_W-1:0] out_rank,
    output entry_t            out_entry,
    output logic              out_last
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_OSCAN = 6'b000010,
        ST_OAPPL = 6'b000100,
        ST_DSCAN = 6'b001000,
        ST_DEMIT = 6'b010000,
        ST_EMPTY = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    entry_t            slot_reg [TABLE_SIZE];
    entry_t            cur_reg;
    entry_t            cand_reg;
    logic [IDX_W-1:0]  cand_idx_reg;
    logic              cand_ok_reg;
    logic              match_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic [CNT_W-1:0]  rank_reg;
    logic [TABLE_SIZE-1:0] done_reg;
    logic              out_valid_reg;
    logic              out_res_reg;
    logic [RANK_W-1:0] out_rank_reg;
    entry_t            out_entry_reg;
    logic              out_last_reg;

    logic [IDX_W-1:0]  scan_idx;
    entry_t            slot_rd;
    logic              scan_end;
    logic              out_free;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              is_last;

    assign scan_idx = scan_reg[IDX_W-1:0];
    assign slot_rd  = slot_reg[scan_idx];
    assign scan_end = (scan_reg == fill_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign is_last  = ((rank_reg + CNT_W'(1)) == fill_reg);
    assign pop      = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        wr_en  = 1'b0;
        wr_idx = match_idx_reg;
        if (state_reg == ST_OAPPL) begin
            if (match_reg) begin
                wr_en = 1'b1;
            end else if (fill_reg < CNT_W'(TABLE_SIZE)) begin
                wr_en  = 1'b1;
                wr_idx = fill_reg[IDX_W-1:0];
            end else if (ranks_before(cur_reg, cand_reg)) begin
                wr_en  = 1'b1;
                wr_idx = cand_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_idx] <= cur_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.kind == CMD_OFFER) begin
                        state_next = ST_OSCAN;
                    end else if (fill_reg == '0) begin
                        state_next = ST_EMPTY;
                    end else begin
                        state_next = ST_DSCAN;
                    end
                end
            end
            ST_OSCAN: if (scan_end) state_next = ST_OAPPL;
            ST_OAPPL: state_next = ST_IDLE;
            ST_DSCAN: if (scan_end) state_next = ST_DEMIT;
            ST_DEMIT: begin
                if (out_free) begin
                    state_next = is_last ? ST_IDLE : ST_DSCAN;
                end
            end
            ST_EMPTY: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en && !match_reg && (fill_reg < CNT_W'(TABLE_SIZE))) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if ((state_reg == ST_DEMIT) && out_free) begin
                out_valid_reg <= 1'b1;
                if (is_last) begin
                    fill_reg <= '0;
                    done_reg <= '0;
                end else begin
                    done_reg[cand_idx_reg] <= 1'b1;
                end
            end
            if ((state_reg == ST_EMPTY) && out_free) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cur_reg     <= q_cmd.entry;
                scan_reg    <= '0;
                rank_reg    <= '0;
                cand_ok_reg <= 1'b0;
                match_reg   <= 1'b0;
            end
            ST_OSCAN: begin
                if (!scan_end) begin
                    scan_reg <= scan_reg + CNT_W'(1);
                    if (slot_rd.id == cur_reg.id) begin
                        match_reg     <= 1'b1;
                        match_idx_reg <= scan_idx;
                    end
                    // worst entry so far
                    if (!cand_ok_reg || ranks_before(cand_reg, slot_rd)) begin
                        cand_ok_reg  <= 1'b1;
                        cand_reg     <= slot_rd;
                        cand_idx_reg <= scan_idx;
                    end
                end
            end
            ST_DSCAN: begin
                if (!scan_end) begin
                    scan_reg <= scan_reg + CNT_W'(1);
                    // best entry not yet emitted
                    if (!done_reg[scan_idx]
                        && (!cand_ok_reg || ranks_before(slot_rd, cand_reg))) begin
                        cand_ok_reg  <= 1'b1;
                        cand_reg     <= slot_rd;
                        cand_idx_reg <= scan_idx;
                    end
                end
            end
            ST_DEMIT: begin
                if (out_free) begin
                    out_res_reg   <= 1'b1;
                    out_rank_reg  <= RANK_W'(rank_reg);
                    out_entry_reg <= cand_reg;
                    out_last_reg  <= is_last;
                    rank_reg      <= rank_reg + CNT_W'(1);
                    scan_reg      <= '0;
                    cand_ok_reg   <= 1'b0;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_res_reg   <= 1'b0;
                    out_rank_reg  <= '0;
                    out_entry_reg <= '0;
                    out_last_reg  <= 1'b1;
                end
            end
            default: begin
                scan_reg <= scan_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_rank  = out_rank_reg;
    assign out_entry = out_entry_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/core/top_k_keyed_ranking_table.sv]
// ----------------------------------------------------------------------------
// top_k_keyed_ranking_table - bounded top-k table with key update
// keeps the best entries by score, date and id; drains them in rank order
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser     | tlast
//  s_      | in  | id, score, date, days_rem, group       | op        | -
//  m_      | out | rank, id, score, date, days_rem, group | valid_res | last
//  cfg_    | in  | target_year on cfg_wdata               | -         | -
//
// an offer scans the filled slots in the back end, one slot read per cycle,
// then applies the entry; dropped offers cost nothing behind the queue
// a drain runs one selection scan of the slot store per emitted word
// reset clears the fill count, the queue and the output valid flag
// the two-entry queue keeps accepting words while the back end works, until
// it is full, and the back end holds a finished word while m_tready is low
// ----------------------------------------------------------------------------
module top_k_keyed_ranking_table import tkr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [YEAR_W-1:0] cfg_wdata,     // target_year
    // input words
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [127:0]      s_tdata,       // id, score, date, days_rem, group, zero pad
    input  logic              s_tuser,       // op: 0 offer, 1 drain
    // result words
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [135:0]      m_tdata,       // rank, id, score, date, days_rem, group, pad
    output logic              m_tuser,       // valid_res
    output logic              m_tlast        // last word of a drain
);

    localparam int ENTRY_W = $bits(entry_t);

    entry_t            in_entry;
    logic              push;
    cmd_t              push_cmd;
    logic              q_full;
    logic              q_valid;
    cmd_t              q_cmd;
    logic              pop;
    logic [RANK_W-1:0] out_rank;
    entry_t            out_entry;

    // entry struct packs with the id in the low bits, same as the bus
    assign in_entry = entry_t'(s_tdata[ENTRY_W-1:0]);

    tkr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_entry (in_entry),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // classified commands wait here
    tkr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop)
    );

    // slot store, scans and the output register
    tkr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (m_tuser),
        .out_rank (out_rank),
        .out_entry(out_entry),
        .out_last (m_tlast)
    );

    // rank in the low bits, then the entry, zero pad on top
    assign m_tdata = {{(136 - RANK_W - ENTRY_W){1'b0}}, out_entry, out_rank};

endmodule

[rtl/core/tkr_checker.sv]
// ----------------------------------------------------------------------------
// tkr_checker - port-level checks of the ranking table
// watches result words for rank sequence, stall hold, empty drains and reset
// ----------------------------------------------------------------------------
module tkr_checker import tkr_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [135:0]      m_tdata,
    input logic              m_tuser,
    input logic              m_tlast
);

    logic [RANK_W-1:0] exp_rank_reg;

    // rank expected on the next result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_rank_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            exp_rank_reg <= m_tlast ? '0 : exp_rank_reg + RANK_W'(1);
        end
    end

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word shown right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("empty drain word malformed");

    a_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[RANK_W-1:0] == exp_rank_reg)
        else $error("rank out of sequence");

endmodule

bind top_k_keyed_ranking_table tkr_checker u_tkr_checker (.*);
